[rtl/snm_pkg.sv]
// ----------------------------------------------------------------------------
// snm_pkg: shared types and constants of the substring matcher
// Lane width, lane count, register indexes and the types passed between
// the window cells and the top level.
// ----------------------------------------------------------------------------
package snm_pkg;

   // Window geometry
   localparam int MAX_PATTERN = 8;
   localparam int LANES       = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
   localparam int LANE_BITS   = (LANES > 1) ? $clog2(LANES) : 1;
   localparam int LEN_BITS    = 4;

   // Position and count
   localparam int POSITION_BITS = 16;
   localparam int FIELD_BITS    = 16;

   // Configuration register indexes
   localparam int CSR_ADDR_BITS = 1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_PATTERN_BYTES  = 1'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_PATTERN_LENGTH = 1'd1;

   typedef logic [7:0][7:0] pattern_type;

   // One window lane as handed from cell to cell
   typedef struct packed {
      logic       valid;
      logic [7:0] data;
   } lane_type;

endpackage

[rtl/snm_cell.sv]
// ----------------------------------------------------------------------------
// snm_cell: one lane of the sliding text window
// Holds one window byte with its fill flag, passes it to the next lane on
// every accepted item and compares the byte arriving from the left against
// the pattern byte that lines up with this lane.
// ----------------------------------------------------------------------------
module snm_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  logic                                flush,
   input  logic [snm_pkg::LANE_BITS-1:0]       cell_index,
   input  logic [snm_pkg::LEN_BITS-1:0]        length,
   input  snm_pkg::pattern_type                pattern,
   input  snm_pkg::lane_type                   lane_in,
   output snm_pkg::lane_type                   lane_out,
   output logic                                hit
);

   logic                             valid_ff;
   logic                             valid_in;
   logic [7:0]                       data_ff;
   logic [snm_pkg::LEN_BITS-1:0]     index_ext;
   logic [snm_pkg::LEN_BITS-1:0]     sel_full;
   logic [2:0]                       sel;
   logic                             unused_lane;

   assign index_ext   = snm_pkg::LEN_BITS'(cell_index);
   assign sel_full    = length - 4'd1 - index_ext;
   assign sel         = sel_full[2:0];
   assign unused_lane = (index_ext >= length);

   // Lane beyond the pattern always agrees; others need a filled, equal byte
   assign hit = unused_lane || (lane_in.valid && (lane_in.data == pattern[sel]));

   // Drop the fill flag after the last byte of a text
   assign valid_in = flush ? 1'b0 : lane_in.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= lane_in.data;
      end
   end

   assign lane_out.valid = valid_ff;
   assign lane_out.data  = data_ff;

endmodule

[rtl/nonoverlapping_substring_matcher_top.sv]
// ----------------------------------------------------------------------------
// nonoverlapping_substring_matcher_top: streaming non-overlapping search
// Takes one text byte per item and returns one result item per byte.
// ----------------------------------------------------------------------------
// The block accepts one text byte every clock cycle and returns its result
// in the next cycle from an output register; a new byte is taken while the
// previous result waits, as long as the output register is empty or being
// drained in the same cycle. The text window is a row of eight byte cells
// that shift on each item and compare in parallel against the pattern, so
// the whole match decision for a byte is combinational. Matches are leftmost
// first and never overlap; tlast on a byte clears the window, position,
// count and suppression after that byte. Configuration writes take effect
// on the next byte and are meant to happen between items.
module nonoverlapping_substring_matcher_top (
   input  logic        clock,
   input  logic        reset,
   // Text items
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic        req_tlast,   // end_of_text
   // Result items
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] match_position, [31:16] match_total
   output logic        rsp_tuser,   // [0] match_found
   // Configuration writes
   input  logic                               csr_we,
   input  logic [snm_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [63:0]                        csr_wdata
);

   localparam logic [snm_pkg::POSITION_BITS-1:0] POS_MAX   = '1;
   localparam logic [snm_pkg::FIELD_BITS-1:0]    COUNT_MAX = '1;

   snm_pkg::pattern_type              pattern_ff;
   logic [snm_pkg::LEN_BITS-1:0]      length_ff;

   logic [snm_pkg::POSITION_BITS-1:0] pos_ff, pos_in;
   logic [snm_pkg::FIELD_BITS-1:0]    count_ff, count_in;
   logic [2:0]                        suppress_ff, suppress_in;

   logic                              rsp_valid_ff;
   logic                              found_ff, found_in;
   logic [snm_pkg::FIELD_BITS-1:0]    start_ff, start_in;
   logic [snm_pkg::FIELD_BITS-1:0]    total_ff;

   logic                              accept;
   logic                              pos_sat;
   logic                              len_ok;
   logic                              window_hit;
   logic [snm_pkg::POSITION_BITS-1:0] start_full;
   logic [snm_pkg::POSITION_BITS-1:0] len_ext;

   snm_pkg::lane_type                 lanes [snm_pkg::LANES];
   logic [snm_pkg::LANES-1:0]         hits;

   // Take a new item whenever the output register is free or draining
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         length_ff  <= '0;
      end else if (csr_we) begin
         unique case (csr_addr)
            snm_pkg::REG_PATTERN_BYTES:  pattern_ff <= csr_wdata;
            snm_pkg::REG_PATTERN_LENGTH: length_ff  <= csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   // Window cells: lane 0 takes the new byte, each cell feeds the next
   assign lanes[0].valid = 1'b1;
   assign lanes[0].data  = req_tdata;

   for (genvar k = 0; k < snm_pkg::LANES; k++) begin : g_cell
      if (k < snm_pkg::LANES - 1) begin : g_mid
         snm_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .advance    (accept),
            .flush      (req_tlast),
            .cell_index (snm_pkg::LANE_BITS'(k)),
            .length     (length_ff),
            .pattern    (pattern_ff),
            .lane_in    (lanes[k]),
            .lane_out   (lanes[k+1]),
            .hit        (hits[k])
         );
      end else begin : g_end
         snm_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .advance    (accept),
            .flush      (req_tlast),
            .cell_index (snm_pkg::LANE_BITS'(k)),
            .length     (length_ff),
            .pattern    (pattern_ff),
            .lane_in    (lanes[k]),
            .lane_out   (),
            .hit        (hits[k])
         );
      end
   end

   // Match decision
   assign len_ok     = (length_ff != '0) && (length_ff <= snm_pkg::LEN_BITS'(snm_pkg::LANES));
   assign window_hit = len_ok && (&hits);
   assign pos_sat    = (pos_ff == POS_MAX);
   assign len_ext    = snm_pkg::POSITION_BITS'(length_ff);
   assign start_full = pos_sat ? POS_MAX
                               : pos_ff + snm_pkg::POSITION_BITS'(2) - len_ext;

   always_comb begin
      found_in    = 1'b0;
      start_in    = '0;
      count_in    = count_ff;
      suppress_in = suppress_ff;
      pos_in      = pos_sat ? pos_ff : pos_ff + snm_pkg::POSITION_BITS'(1);
      if (suppress_ff != '0) begin
         suppress_in = suppress_ff - 3'd1;
      end else if (window_hit) begin
         found_in    = 1'b1;
         start_in    = snm_pkg::FIELD_BITS'(start_full);
         suppress_in = 3'(length_ff - 4'd1);
         if (count_ff != COUNT_MAX) begin
            count_in = count_ff + snm_pkg::FIELD_BITS'(1);
         end
      end
   end

   // Running state, cleared after the last byte of a text
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff      <= '0;
         count_ff    <= '0;
         suppress_ff <= '0;
      end else if (accept) begin
         if (req_tlast) begin
            pos_ff      <= '0;
            count_ff    <= '0;
            suppress_ff <= '0;
         end else begin
            pos_ff      <= pos_in;
            count_ff    <= count_in;
            suppress_ff <= suppress_in;
         end
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         found_ff <= found_in;
         start_ff <= start_in;
         total_ff <= count_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = found_ff;
   assign rsp_tdata  = {total_ff, start_ff};

`ifndef ASSERT_OFF
   // No start position without a match
   a_pos_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[15:0] == '0)
      else $error("start position set without a match");

   // A match always counts
   a_count_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata[31:16] != '0)
      else $error("match reported with zero total");

   // Suppressed byte never reports a match
   a_suppress: assert property (@(posedge clock) disable iff (reset)
      accept && (suppress_ff != '0) |=> !rsp_tuser)
      else $error("match reported inside a suppressed span");

   // Last byte clears the running state
   a_clear: assert property (@(posedge clock) disable iff (reset)
      accept && req_tlast |=> (pos_ff == '0) && (count_ff == '0) && (suppress_ff == '0))
      else $error("state not cleared after last byte");
`endif

endmodule

[dv/nonoverlapping_substring_matcher_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// nonoverlapping_substring_matcher_top_tb: self-checking bench of the matcher
// Streams text bytes into the block, predicts every result item with a
// cycle-free model of the window search, and compares each result field by
// field. Covers disabled and oversized lengths, short texts, overlap
// suppression, register changes within a text, and random texts built
// around the pattern under back-pressure.
// ----------------------------------------------------------------------------
module nonoverlapping_substring_matcher_top_tb;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int RANDOM_ITEMS = 1200;
   localparam int PHASE_ITEMS = 150;

   typedef struct packed {
      logic        found;
      logic [15:0] position;
      logic [15:0] total;
   } match_result_type;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic        rsp_tuser;
   logic                               csr_we = 1'b0;
   logic [snm_pkg::CSR_ADDR_BITS-1:0]  csr_addr = snm_pkg::REG_PATTERN_BYTES;
   logic [63:0]                        csr_wdata = 64'h0;

   nonoverlapping_substring_matcher_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // Matcher model: registers and search state
   logic [63:0] cfg_pattern = 64'h0;
   logic [3:0]  cfg_length = 4'd0;
   logic [7:0]  win_bytes [8];
   logic [3:0]  win_fill;
   logic [15:0] seen_bytes;
   logic [15:0] match_count;
   logic [2:0]  hold_off;

   match_result_type expected_q [$];
   bit          gaps_on = 1'b1;
   int          fault_count = 0;
   int          bytes_accepted = 0;
   int          results_seen = 0;
   int          matches_seen = 0;
   int          texts_sent = 0;
   int          cycle_count = 0;

   // Clear window, position, count and suppression
   function automatic void clear_search();
      for (int k = 0; k < 8; k++) win_bytes[k] = 8'h00;
      win_fill = 4'd0;
      seen_bytes = 16'd0;
      match_count = 16'd0;
      hold_off = 3'd0;
   endfunction

   // Advance the model by one text byte and return its result item
   function automatic match_result_type search_step(logic [7:0] text_byte, logic last);
      match_result_type r;
      logic          pos_sat;
      logic [16:0]   cur_pos;
      logic          hit;
      r = '0;
      pos_sat = (seen_bytes == 16'hFFFF);
      cur_pos = pos_sat ? 17'hFFFF : {1'b0, seen_bytes} + 17'd1;
      for (int k = 7; k > 0; k--) win_bytes[k] = win_bytes[k-1];
      win_bytes[0] = text_byte;
      if (win_fill < 4'd8) win_fill = win_fill + 4'd1;
      if (!pos_sat) seen_bytes = seen_bytes + 16'd1;
      if (hold_off != 3'd0) begin
         hold_off = hold_off - 3'd1;
      end else begin
         hit = (cfg_length != 4'd0) && (cfg_length <= 4'd8) && (win_fill >= cfg_length);
         for (int k = 0; k < 8; k++) begin
            if (hit && k < cfg_length &&
                win_bytes[cfg_length - 1 - k] != cfg_pattern[8*k +: 8]) hit = 1'b0;
         end
         if (hit) begin
            r.found = 1'b1;
            r.position = pos_sat ? 16'hFFFF : 16'(cur_pos - {13'd0, cfg_length} + 17'd1);
            if (match_count != 16'hFFFF) match_count = match_count + 16'd1;
            hold_off = 3'(cfg_length - 4'd1);
         end
      end
      r.total = match_count;
      if (last) clear_search();
      return r;
   endfunction

   // Clock
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_count, expected_q.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver back-pressure
   always @(posedge clock) begin
      rsp_tready <= !gaps_on || ($urandom_range(99) >= 12);
   end

   task automatic report_fault(string what, match_result_type want, match_result_type got);
      if (fault_count < 10)
         $display("%0t: %s: expected found=%0b pos=%0d total=%0d, got found=%0b pos=%0d total=%0d",
                  $realtime, what, want.found, want.position, want.total,
                  got.found, got.position, got.total);
      fault_count++;
   endtask

   // Predict on each accepted text item, then check each accepted result item
   always @(posedge clock) begin
      match_result_type want;
      match_result_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            expected_q.push_back(search_step(req_tdata, req_tlast));
            bytes_accepted++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.found = rsp_tuser;
            got.position = rsp_tdata[15:0];
            got.total = rsp_tdata[31:16];
            results_seen++;
            if (got.found) matches_seen++;
            if (expected_q.size() == 0) begin
               report_fault("result with nothing expected", '0, got);
            end else begin
               want = expected_q.pop_front();
               if (want.found !== got.found || want.position !== got.position ||
                   want.total !== got.total)
                  report_fault("result mismatch", want, got);
            end
         end
      end
   end

   // Send one text item and hold it until accepted
   task automatic send_text_byte(logic [7:0] text_byte, logic last);
      if (gaps_on && $urandom_range(99) < 12) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= text_byte;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      if (last) texts_sent++;
   endtask

   // Stop sending and wait until every expected result has arrived
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (expected_q.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   // Write one register while the block is idle
   task automatic write_reg(logic [snm_pkg::CSR_ADDR_BITS-1:0] index, logic [63:0] value);
      csr_we <= 1'b1;
      csr_addr <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == snm_pkg::REG_PATTERN_BYTES) cfg_pattern = value;
      else cfg_length = value[3:0];
      @(posedge clock);
   endtask

   // Lengths zero and above eight never match
   task automatic test_disabled_lengths();
      send_text_byte(8'h00, 1'b0);
      send_text_byte(8'h00, 1'b1);
      drain();
      write_reg(snm_pkg::REG_PATTERN_LENGTH, 64'd9);
      send_text_byte(8'h00, 1'b0);
      send_text_byte(8'h00, 1'b1);
      drain();
      write_reg(snm_pkg::REG_PATTERN_LENGTH, 64'hFFFF_FFFF_FFFF_FFFF);
      send_text_byte(8'h00, 1'b1);
      drain();
   endtask

   // Full-length pattern: a match at the eighth byte of a nine-byte text, then suppression after it
   task automatic test_full_length();
      write_reg(snm_pkg::REG_PATTERN_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(snm_pkg::REG_PATTERN_LENGTH, 64'd8);
      for (int k = 0; k < 9; k++) send_text_byte(8'hFF, k == 8);
      drain();
   endtask

   // Overlap suppression kept across a register change within a text
   task automatic test_change_mid_text();
      write_reg(snm_pkg::REG_PATTERN_BYTES, 64'h61_62_61);
      write_reg(snm_pkg::REG_PATTERN_LENGTH, 64'd3);
      send_text_byte(8'h61, 1'b0);
      send_text_byte(8'h62, 1'b0);
      send_text_byte(8'h61, 1'b0);
      drain();
      write_reg(snm_pkg::REG_PATTERN_LENGTH, 64'd1);
      send_text_byte(8'h61, 1'b0);
      send_text_byte(8'h61, 1'b0);
      send_text_byte(8'h61, 1'b1);
      drain();
   endtask

   // Random texts around a pattern, several settings, some texts left open
   task automatic test_random_texts();
      logic [7:0]  text_q [$];
      logic [7:0]  sym [2];
      logic [63:0] pattern;
      int          len;
      int          use_len;
      int          phase;
      int          sent;
      int          phase_sent;
      int          r;
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS || phase < 5) begin
         // Pick a setting; the first phases cover the extremes
         sym[0] = $urandom_range(255);
         sym[1] = $urandom_range(255);
         if (phase == 2) begin
            sym[0] = 8'h00;
            sym[1] = 8'hFF;
         end
         r = $urandom_range(99);
         len = (r < 6) ? 0 : (r < 12) ? $urandom_range(9, 15) : $urandom_range(1, 8);
         if (phase == 0) len = 8;
         if (phase == 1) len = 1;
         pattern = {$urandom, $urandom};
         if (phase != 3) begin
            for (int k = 0; k < 8; k++) pattern[8*k +: 8] = sym[$urandom_range(1)];
         end
         write_reg(snm_pkg::REG_PATTERN_BYTES, pattern);
         write_reg(snm_pkg::REG_PATTERN_LENGTH,
                   {$urandom, $urandom_range(15, 0) << 4 | 32'(len)});
         use_len = (len > 8) ? 8 : len;
         gaps_on = (phase != 4);
         phase_sent = 0;
         while (phase_sent < PHASE_ITEMS) begin
            // Build one text: pattern copies, alphabet bytes and noise
            text_q.delete();
            repeat ($urandom_range(1, 30)) begin
               r = $urandom_range(99);
               if (r < 35) begin
                  for (int k = 0; k < use_len; k++) text_q.push_back(pattern[8*k +: 8]);
               end else if (r < 85) begin
                  text_q.push_back(sym[$urandom_range(1)]);
               end else begin
                  text_q.push_back($urandom_range(255));
               end
            end
            for (int k = 0; k < text_q.size(); k++) begin
               send_text_byte(text_q[k],
                              k == text_q.size() - 1 &&
                              (phase_sent + k + 1 < PHASE_ITEMS || $urandom_range(1)));
            end
            phase_sent += text_q.size();
         end
         sent += phase_sent;
         drain();
         phase++;
      end
      gaps_on = 1'b1;
   endtask

   // Test sequence
   initial begin
      clear_search();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_disabled_lengths();
      test_full_length();
      test_change_mid_text();
      test_random_texts();
      drain();
      if (expected_q.size() != 0) begin
         $display("%0d expected results never arrived", expected_q.size());
         fault_count++;
      end
      $display("sent %0d text bytes in %0d closed texts; %0d results, %0d matches",
               bytes_accepted, texts_sent, results_seen, matches_seen);
      $display("covered disabled lengths, overlap suppression, random texts, %0d faults",
               fault_count);
      if (fault_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/snm_pkg.sv
rtl/snm_cell.sv
rtl/nonoverlapping_substring_matcher_top.sv
dv/nonoverlapping_substring_matcher_top_tb.sv
